// ===== hw/rtl/legp_pkg.sv =====
// Shared widths, constants, command/status types and the Legendre coefficient table
// for the Legendre value and slope block. No dependencies.
package legp_pkg;

    localparam int ORDER_W    = 4;
    localparam int X_W        = 31;
    localparam int H_W        = 32;
    localparam int VAL_W      = 31;
    localparam int SLOPE_W    = 48;
    localparam int ACC_W      = 48;
    localparam int COEF_W     = 18;
    localparam int WCOEF_W    = 23;
    localparam int ROM_DEPTH  = 66;
    localparam int ROM_AW     = 7;
    localparam int COEF_SHIFT = 21;
    localparam int Q_SHIFT    = 29;
    localparam int LO_W       = 24;
    localparam int PLO_W      = LO_W + 1 + X_W;
    localparam int PHI_W      = ACC_W - LO_W + X_W;
    localparam int PROD_W     = 80;
    localparam int N_SHIFT    = 12;
    localparam int DVD_W      = 60;
    localparam int CNT_W      = 6;

    localparam logic signed [X_W-1:0]     X_ONE     = 31'sd536870912;
    localparam logic signed [VAL_W-1:0]   VAL_MAX   = 31'sh3FFF_FFFF;
    localparam logic signed [VAL_W-1:0]   VAL_MIN   = 31'sh4000_0000;
    localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = 48'sh8000_0000_0000;

    // Numerators over 256, lowest power first, order k starts at k(k+1)/2
    localparam logic signed [COEF_W-1:0] COEF_TABLE [ROM_DEPTH] = '{
        18'sd256,
        18'sd0, 18'sd256,
        -18'sd128, 18'sd0, 18'sd384,
        18'sd0, -18'sd384, 18'sd0, 18'sd640,
        18'sd96, 18'sd0, -18'sd960, 18'sd0, 18'sd1120,
        18'sd0, 18'sd480, 18'sd0, -18'sd2240, 18'sd0, 18'sd2016,
        -18'sd80, 18'sd0, 18'sd1680, 18'sd0, -18'sd5040, 18'sd0, 18'sd3696,
        18'sd0, -18'sd560, 18'sd0, 18'sd5040, 18'sd0, -18'sd11088, 18'sd0, 18'sd6864,
        18'sd70, 18'sd0, -18'sd2520, 18'sd0, 18'sd13860, 18'sd0, -18'sd24024, 18'sd0,
        18'sd12870,
        18'sd0, 18'sd630, 18'sd0, -18'sd9240, 18'sd0, 18'sd36036, 18'sd0, -18'sd51480,
        18'sd0, 18'sd24310,
        -18'sd63, 18'sd0, 18'sd3465, 18'sd0, -18'sd30030, 18'sd0, 18'sd90090, 18'sd0,
        -18'sd109395, 18'sd0, 18'sd46189
    };

    typedef struct packed {
        logic load;
        logic init;
        logic to_slope;
        logic mlo;
        logic mhi;
        logic acc;
        logic div_start;
        logic div_step;
        logic push;
    } legp_cmd_t;

    typedef struct packed {
        logic in_err;
        logic more;
        logic slope_mode;
        logic div_last;
        logic out_free;
    } legp_stat_t;

    function automatic logic signed [COEF_W-1:0] coef_rom(input logic [ROM_AW-1:0] idx);
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (idx < ROM_AW'(ROM_DEPTH))
        begin
            c = COEF_TABLE[idx];
        end
        return c;
    endfunction

    function automatic logic [ROM_AW-1:0] base_of(input logic [ORDER_W-1:0] k);
        logic [2*ORDER_W-1:0] p;
        p = {{ORDER_W{1'b0}}, k} * ({{ORDER_W{1'b0}}, k} + (2*ORDER_W)'(1));
        return p[ROM_AW:1];
    endfunction

endpackage

// ===== hw/rtl/legp_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on legp_pkg for field widths.
interface legp_in_if;
    logic                               valid;
    logic                               ready;
    logic [legp_pkg::ORDER_W-1:0]       poly_order;
    logic signed [legp_pkg::X_W-1:0]    x_point;
    logic [legp_pkg::H_W-1:0]           bin_width;

    modport source (output valid, output poly_order, output x_point, output bin_width,
                    input ready);
    modport sink (input valid, input poly_order, input x_point, input bin_width,
                  output ready);
endinterface

interface legp_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [legp_pkg::VAL_W-1:0]   poly_value;
    logic signed [legp_pkg::SLOPE_W-1:0] scaled_slope;
    logic                                status;

    modport source (output valid, output poly_value, output scaled_slope, output status,
                    input ready);
    modport sink (input valid, input poly_value, input scaled_slope, input status,
                  output ready);
endinterface

// ===== hw/rtl/legp_ctrl.sv =====
// Sequencer for the Legendre block: steps the Horner passes and the divider.
// Depends on legp_pkg for the command and status structs.
module legp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output legp_pkg::legp_cmd_t    cmd,
    input  legp_pkg::legp_stat_t   st
);
    import legp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_INIT = 7'b0000010,
        S_TEST = 7'b0000100,
        S_MLO  = 7'b0001000,
        S_MHI  = 7'b0010000,
        S_ACC  = 7'b0100000,
        S_DIV  = 7'b1000000
    } ctrl_state_t;

    // the result hand-off shares the divider's exit; DONE is its own code
    typedef enum logic [1:0] {
        H_RUN  = 2'b01,
        H_DONE = 2'b10
    } hand_state_t;

    ctrl_state_t state_reg, state_next;
    hand_state_t hand_reg, hand_next;

    always_comb
    begin
        state_next = state_reg;
        hand_next  = hand_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        if (hand_reg == H_DONE)
        begin
            // hold until the output register can take the beat
            if (st.out_free)
            begin
                cmd.push  = 1'b1;
                hand_next = H_RUN;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load = 1'b1;
                        if (st.in_err)
                        begin
                            hand_next = H_DONE;
                        end
                        else
                        begin
                            state_next = S_INIT;
                        end
                    end
                end
                S_INIT:
                begin
                    cmd.init   = 1'b1;
                    state_next = S_TEST;
                end
                S_TEST:
                begin
                    priority if (st.more)
                    begin
                        state_next = S_MLO;
                    end
                    else if (!st.slope_mode)
                    begin
                        cmd.to_slope = 1'b1;
                        state_next   = S_INIT;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
                S_MLO:
                begin
                    cmd.mlo    = 1'b1;
                    state_next = S_MHI;
                end
                S_MHI:
                begin
                    cmd.mhi    = 1'b1;
                    state_next = S_ACC;
                end
                S_ACC:
                begin
                    cmd.acc    = 1'b1;
                    state_next = S_TEST;
                end
                S_DIV:
                begin
                    cmd.div_step = 1'b1;
                    if (st.div_last)
                    begin
                        state_next = S_IDLE;
                        hand_next  = H_DONE;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hand_reg  <= H_RUN;
        end
        else
        begin
            state_reg <= state_next;
            hand_reg  <= hand_next;
        end
    end

    a_err_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && st.in_err |=> hand_reg == H_DONE && state_reg == S_IDLE)
        else $error("bad order did not go straight to result hand-off");

    a_ok_to_init: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !st.in_err |=> state_reg == S_INIT)
        else $error("accepted item did not start the value pass");

    a_div_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step && st.div_last |=> hand_reg == H_DONE)
        else $error("divider finished without result hand-off");

endmodule

// ===== hw/rtl/legp_dpath.sv =====
// Datapath for the Legendre block: coefficient table, shared 25x31 multiplier
// used half by half, Horner accumulator, restoring divider, output register.
// Depends on legp_pkg.
module legp_dpath #(
    parameter int MAX_ORDER = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  legp_pkg::legp_cmd_t                 cmd,
    output legp_pkg::legp_stat_t                st,
    input  logic [legp_pkg::ORDER_W-1:0]        poly_order,
    input  logic signed [legp_pkg::X_W-1:0]     x_point,
    input  logic [legp_pkg::H_W-1:0]            bin_width,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [legp_pkg::VAL_W-1:0]   poly_value,
    output logic signed [legp_pkg::SLOPE_W-1:0] scaled_slope,
    output logic                                status
);
    import legp_pkg::*;

    localparam logic [ORDER_W-1:0]      MaxOrd    = ORDER_W'(MAX_ORDER);
    localparam logic signed [PLO_W-1:0] RoundHalf = PLO_W'(1) <<< (Q_SHIFT - 1);
    localparam logic [DVD_W-1:0]        QMaxPos   = DVD_W'(SLOPE_MAX);
    localparam logic [DVD_W-1:0]        QMinMag   = QMaxPos + DVD_W'(1);

    // control state
    logic [ORDER_W-1:0] k_reg, k_next;
    logic [ORDER_W-1:0] t_reg, t_next;
    logic               mode_reg, mode_next;
    logic               err_reg, err_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;

    // payload
    logic [ROM_AW-1:0]          base_reg, base_next;
    logic signed [X_W-1:0]      x_reg, x_next;
    logic [H_W-1:0]             h_reg, h_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [ACC_W-1:0]    term_reg, term_next;
    logic signed [PLO_W-1:0]    plo_reg, plo_next;
    logic signed [PHI_W-1:0]    phi_reg, phi_next;
    logic signed [VAL_W-1:0]    val_reg, val_next;
    logic [H_W-1:0]             rem_reg, rem_next;
    logic [DVD_W-1:0]           dvd_reg, dvd_next;
    logic                       neg_reg, neg_next;
    logic                       dzero_reg, dzero_next;
    logic signed [VAL_W-1:0]    out_value_reg, out_value_next;
    logic signed [SLOPE_W-1:0]  out_slope_reg, out_slope_next;
    logic                       out_status_reg, out_status_next;

    logic                       in_err;
    logic signed [X_W-1:0]      x_clamp;
    logic [ORDER_W-1:0]         cidx;
    logic [ORDER_W-1:0]         weight;
    logic [ROM_AW-1:0]          rom_addr;
    logic signed [WCOEF_W-1:0]  wcoef;
    logic signed [ACC_W-1:0]    term;
    logic signed [LO_W:0]       lo_op;
    logic signed [ACC_W-LO_W-1:0] hi_op;
    logic signed [LO_W:0]       mul_op;
    logic signed [PLO_W-1:0]    mul_prod;
    logic signed [PROD_W-1:0]   prod_sum;
    logic signed [ACC_W-1:0]    acc_step;
    logic signed [VAL_W-1:0]    val_sat;
    logic [ACC_W-1:0]           dmag;
    logic [DVD_W-1:0]           dvd_init;
    logic [H_W:0]               rem_shift;
    logic                       sub_ok;
    logic signed [SLOPE_W-1:0]  slope_fin;

    assign in_err = poly_order > MaxOrd;

    always_comb
    begin
        priority if (x_point > X_ONE)
        begin
            x_clamp = X_ONE;
        end
        else if (x_point < -X_ONE)
        begin
            x_clamp = -X_ONE;
        end
        else
        begin
            x_clamp = x_point;
        end
    end

    // table read: top coefficient on init, next lower one while multiplying
    assign cidx     = cmd.mlo ? t_reg - ORDER_W'(1) : t_reg;
    assign weight   = mode_reg ? cidx : ORDER_W'(1);
    assign rom_addr = base_reg + ROM_AW'(cidx);
    assign wcoef    = $signed({1'b0, weight}) * coef_rom(rom_addr);
    assign term     = ACC_W'(wcoef) <<< COEF_SHIFT;

    assign lo_op    = $signed({1'b0, acc_reg[LO_W-1:0]});
    assign hi_op    = $signed(acc_reg[ACC_W-1:LO_W]);
    // one multiplier: low half of the accumulator first, high half next cycle
    assign mul_op   = cmd.mlo ? lo_op : (LO_W+1)'(hi_op);
    assign mul_prod = mul_op * x_reg;
    assign prod_sum = (PROD_W'(phi_reg) <<< LO_W) + PROD_W'(plo_reg);
    assign acc_step = $signed(prod_sum[Q_SHIFT+ACC_W-1:Q_SHIFT]) + term_reg;

    always_comb
    begin
        priority if (acc_reg < ACC_W'(VAL_MIN))
        begin
            val_sat = VAL_MIN;
        end
        else if (acc_reg > ACC_W'(VAL_MAX))
        begin
            val_sat = VAL_MAX;
        end
        else
        begin
            val_sat = acc_reg[VAL_W-1:0];
        end
    end

    assign dmag      = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : acc_reg;
    assign dvd_init  = (DVD_W'(dmag) << N_SHIFT) + DVD_W'(h_reg >> 1);
    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign sub_ok    = rem_shift >= {1'b0, h_reg};

    always_comb
    begin
        priority if (h_reg == '0)
        begin
            slope_fin = neg_reg ? SLOPE_MIN : (dzero_reg ? '0 : SLOPE_MAX);
        end
        else if (neg_reg)
        begin
            slope_fin = (dvd_reg > QMinMag) ? SLOPE_MIN : -$signed(dvd_reg[SLOPE_W-1:0]);
        end
        else
        begin
            slope_fin = (dvd_reg > QMaxPos) ? SLOPE_MAX : $signed(dvd_reg[SLOPE_W-1:0]);
        end
    end

    always_comb
    begin
        k_next          = k_reg;
        t_next          = t_reg;
        mode_next       = mode_reg;
        err_next        = err_reg;
        cnt_next        = cnt_reg;
        base_next       = base_reg;
        x_next          = x_reg;
        h_next          = h_reg;
        acc_next        = acc_reg;
        term_next       = term_reg;
        plo_next        = plo_reg;
        phi_next        = phi_reg;
        val_next        = val_reg;
        rem_next        = rem_reg;
        dvd_next        = dvd_reg;
        neg_next        = neg_reg;
        dzero_next      = dzero_reg;
        out_value_next  = out_value_reg;
        out_slope_next  = out_slope_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (cmd.load)
        begin
            k_next    = poly_order;
            t_next    = poly_order;
            mode_next = 1'b0;
            err_next  = in_err;
            base_next = base_of(poly_order);
            x_next    = x_clamp;
            h_next    = bin_width;
        end
        if (cmd.init)
        begin
            acc_next = term;
        end
        if (cmd.to_slope)
        begin
            val_next  = val_sat;
            mode_next = 1'b1;
            t_next    = k_reg;
        end
        if (cmd.mlo)
        begin
            term_next = term;
            plo_next  = mul_prod + RoundHalf;
        end
        if (cmd.mhi)
        begin
            phi_next = mul_prod[PHI_W-1:0];
        end
        if (cmd.acc)
        begin
            acc_next = acc_step;
            t_next   = t_reg - ORDER_W'(1);
        end
        if (cmd.div_start)
        begin
            rem_next   = '0;
            dvd_next   = dvd_init;
            cnt_next   = CNT_W'(DVD_W - 1);
            neg_next   = acc_reg[ACC_W-1];
            dzero_next = acc_reg == '0;
        end
        if (cmd.div_step)
        begin
            rem_next = sub_ok ? H_W'(rem_shift - {1'b0, h_reg}) : rem_shift[H_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], sub_ok};
            cnt_next = cnt_reg - CNT_W'(1);
        end
        if (cmd.push)
        begin
            out_valid_next  = 1'b1;
            out_status_next = err_reg;
            out_value_next  = err_reg ? '0 : val_reg;
            out_slope_next  = err_reg ? '0 : slope_fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            t_reg         <= '0;
            mode_reg      <= 1'b0;
            err_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            t_reg         <= t_next;
            mode_reg      <= mode_next;
            err_reg       <= err_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg       <= base_next;
        x_reg          <= x_next;
        h_reg          <= h_next;
        acc_reg        <= acc_next;
        term_reg       <= term_next;
        plo_reg        <= plo_next;
        phi_reg        <= phi_next;
        val_reg        <= val_next;
        rem_reg        <= rem_next;
        dvd_reg        <= dvd_next;
        neg_reg        <= neg_next;
        dzero_reg      <= dzero_next;
        out_value_reg  <= out_value_next;
        out_slope_reg  <= out_slope_next;
        out_status_reg <= out_status_next;
    end

    assign st.in_err     = in_err;
    assign st.more       = mode_reg ? (t_reg > ORDER_W'(1)) : (t_reg != '0);
    assign st.slope_mode = mode_reg;
    assign st.div_last   = cnt_reg == '0;
    assign st.out_free   = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign poly_value   = out_value_reg;
    assign scaled_slope = out_slope_reg;
    assign status       = out_status_reg;

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        t_reg <= k_reg)
        else $error("Horner step index ran past the order");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step && h_reg != '0 |=> rem_reg < h_reg)
        else $error("divider remainder not below the bin width");

    a_push_status: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> out_valid_reg && out_status_reg == $past(err_reg))
        else $error("result beat lost or status mismatch");

endmodule

// ===== hw/rtl/legendre_poly_value_and_slope.sv =====
// Legendre polynomial value and scaled slope, top level.
// Depends on legp_pkg, legp_if, legp_ctrl and legp_dpath.
//
// One input beat (order k, point x in Q2.29, bin width h in Q16.16) gives one result
// beat: P_k(x) in Q2.29 and dP_k/dx * 2/h in Q24.24, both saturating, with status 1
// and zero values for an order above MAX_ORDER. Items are processed one at a time.
// Each Horner step runs on the single shared 25x31 multiplier (low and high half
// products, then the add), and the restoring divider for the 2/h scaling produces
// one quotient bit per cycle over the 60-bit dividend. The next item is accepted
// as soon as the result sits in the output register, even if the sink has not
// yet taken it.
module legendre_poly_value_and_slope #(
    parameter int MAX_ORDER = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    legp_in_if.sink    sample,
    legp_out_if.source result
);
    import legp_pkg::*;

    legp_cmd_t  cmd;
    legp_stat_t st;

    legp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample.ready),
        .cmd      (cmd),
        .st       (st)
    );

    legp_dpath #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .poly_order   (sample.poly_order),
        .x_point      (sample.x_point),
        .bin_width    (sample.bin_width),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .poly_value   (result.poly_value),
        .scaled_slope (result.scaled_slope),
        .status       (result.status)
    );

endmodule
